/* sv/lge_pkg.sv */
// Shared types and constants of the life grid engine.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package lge_pkg;

  // Fixed widths of the beat fields.
  localparam int ROW_W   = 6;
  localparam int MODE_W  = 2;
  localparam int ALIVE_W = 13;
  localparam int GEN_W   = 32;

  // The reported live count saturates at this value.
  localparam logic [ALIVE_W-1:0] ALIVE_MAX = 13'h1fff;

  // Operation requested by an input beat.
  typedef enum logic [MODE_W-1:0] {
    MODE_TOGGLE = 2'd0,
    MODE_READ   = 2'd1,
    MODE_GEN    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // Datapath operation for the current cycle.
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_ZERO_ROW = 4'd1,
    OP_G0       = 4'd2,
    OP_G1       = 4'd3,
    OP_G2       = 4'd4,
    OP_GLD      = 4'd5,
    OP_GCOL     = 4'd6,
    OP_GWR      = 4'd7,
    OP_RD       = 4'd8,
    OP_MOD      = 4'd9,
    OP_DONE     = 4'd10
  } dp_op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    dp_op_t op;
    logic   take;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  in_grid;
    logic  row_last;
    logic  gen_last;
    logic  col_last;
    logic  out_free;
  } status_t;

endpackage

`default_nettype wire

/* sv/lge_in_if.sv */
// Input channel of the life grid engine: valid/ready plus the command fields.
// Depends on lge_pkg for the field widths.
`default_nettype none

interface lge_in_if;
  logic                      valid;
  logic                      ready;
  logic [lge_pkg::MODE_W-1:0] mode;
  logic [lge_pkg::ROW_W-1:0]  row;
  logic [lge_pkg::ROW_W-1:0]  col;

  modport source (output valid, output mode, output row, output col, input ready);
  modport sink   (input valid, input mode, input row, input col, output ready);
endinterface

`default_nettype wire

/* sv/lge_out_if.sv */
// Result channel of the life grid engine: valid/ready plus the result fields.
// Depends on lge_pkg for the field widths.
`default_nettype none

interface lge_out_if;
  logic                        valid;
  logic                        ready;
  logic                        cell_value;
  logic [lge_pkg::ALIVE_W-1:0] alive_count;
  logic [lge_pkg::GEN_W-1:0]   generation;

  modport source (output valid, output cell_value, output alive_count,
                  output generation, input ready);
  modport sink   (input valid, input cell_value, input alive_count,
                  input generation, output ready);
endinterface

`default_nettype wire

/* sv/lge_ctrl.sv */
// Controller state machine of the life grid engine.
// Depends on lge_pkg for the command and status structs.
`default_nettype none

module lge_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire lge_pkg::status_t st,
  output lge_pkg::cmd_t         cmd
);
  import lge_pkg::*;

  typedef enum logic [12:0] {
    S_INIT = 13'b0000000000001,
    S_IDLE = 13'b0000000000010,
    S_DISP = 13'b0000000000100,
    S_CLR  = 13'b0000000001000,
    S_G0   = 13'b0000000010000,
    S_G1   = 13'b0000000100000,
    S_G2   = 13'b0000001000000,
    S_GLD  = 13'b0000010000000,
    S_GCOL = 13'b0000100000000,
    S_GWR  = 13'b0001000000000,
    S_RD   = 13'b0010000000000,
    S_MOD  = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  // Items are taken only between operations; a waiting result does not block.
  assign item_ready = (state == S_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: if (st.row_last) state_next = S_IDLE;
      S_IDLE: if (cmd.take) state_next = S_DISP;
      S_DISP: begin
        unique case (st.mode)
          MODE_CLEAR: state_next = S_CLR;
          MODE_GEN:   state_next = S_G0;
          MODE_TOGGLE,
          MODE_READ:  state_next = st.in_grid ? S_RD : S_DONE;
        endcase
      end
      S_CLR:  if (st.row_last) state_next = S_DONE;
      S_G0:   state_next = S_G1;
      S_G1:   state_next = S_G2;
      S_G2:   state_next = S_GLD;
      S_GLD:  state_next = S_GCOL;
      S_GCOL: if (st.col_last) state_next = S_GWR;
      S_GWR: begin
        if (st.gen_last) begin
          state_next = st.in_grid ? S_RD : S_DONE;
        end else begin
          state_next = S_GLD;
        end
      end
      S_RD:   state_next = S_MOD;
      S_MOD:  state_next = S_DONE;
      S_DONE: if (st.out_free) state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
  end

  // Datapath operation for each state, and the accept strobe.
  always_comb begin
    cmd.take = item_valid && item_ready;
    unique case (state)
      S_INIT, S_CLR: cmd.op = OP_ZERO_ROW;
      S_G0:          cmd.op = OP_G0;
      S_G1:          cmd.op = OP_G1;
      S_G2:          cmd.op = OP_G2;
      S_GLD:         cmd.op = OP_GLD;
      S_GCOL:        cmd.op = OP_GCOL;
      S_GWR:         cmd.op = OP_GWR;
      S_RD:          cmd.op = OP_RD;
      S_MOD:         cmd.op = OP_MOD;
      S_DONE:        cmd.op = OP_DONE;
      default:       cmd.op = OP_NONE;
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  // An accepted beat is always dispatched in the next cycle.
  a_take_disp: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> state == S_DISP)
    else $error("accepted beat not dispatched");

  // The last row of a generation leads to the final read or the result.
  a_gen_end: assert property (@(posedge clk) disable iff (rst)
    state == S_GWR && st.gen_last |=> state == S_RD || state == S_DONE)
    else $error("generation did not end properly");

  // The column sweep runs until its last column.
  a_col_sweep: assert property (@(posedge clk) disable iff (rst)
    state == S_GCOL && !st.col_last |=> state == S_GCOL)
    else $error("column sweep left early");
`endif

endmodule

`default_nettype wire

/* sv/lge_datapath.sv */
// Datapath of the life grid engine: row memory, line buffers, column sweep,
// live and generation counters and the result register. Depends on lge_pkg.
`default_nettype none

module lge_datapath #(
  parameter int GRID_DIM = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lge_pkg::cmd_t                 cmd,
  output lge_pkg::status_t                   st,
  input  wire logic [lge_pkg::MODE_W-1:0]    item_mode,
  input  wire logic [lge_pkg::ROW_W-1:0]     item_row,
  input  wire logic [lge_pkg::ROW_W-1:0]     item_col,
  input  wire logic                          res_ready,
  output logic                               res_valid,
  output logic                               res_cell,
  output logic [lge_pkg::ALIVE_W-1:0]        res_alive,
  output logic [lge_pkg::GEN_W-1:0]          res_gen
);
  import lge_pkg::*;

  localparam int RW = $clog2(GRID_DIM);
  localparam int LW = $clog2(GRID_DIM * GRID_DIM + 1);

  // Grid memory, one row per word.
  logic [GRID_DIM-1:0] grid_mem [GRID_DIM];
  logic [GRID_DIM-1:0] rd_data;
  logic                rd_en;
  logic [RW-1:0]       rd_addr;
  logic                wr_en;
  logic [RW-1:0]       wr_addr;
  logic [GRID_DIM-1:0] wr_data;

  // Latched item.
  mode_t            lat_mode;
  logic [ROW_W-1:0] lat_row;
  logic [ROW_W-1:0] lat_col;
  logic             in_grid;
  logic [31:0]      row_ext;
  logic [31:0]      col_ext;
  logic [RW-1:0]    row_a;
  logic [RW-1:0]    col_a;

  // Sweep state: row and column counters, line buffers and shift windows.
  logic [RW-1:0]       rr;
  logic [RW-1:0]       cc;
  logic [GRID_DIM-1:0] above;
  logic [GRID_DIM-1:0] here;
  logic [GRID_DIM-1:0] below;
  logic [GRID_DIM-1:0] sa;
  logic [GRID_DIM-1:0] sh;
  logic [GRID_DIM-1:0] sb;
  logic [GRID_DIM-3:0] comp;
  logic [3:0]          nsum;
  logic                nxt;

  // Counters and result.
  logic [LW-1:0]    live_total;
  logic [GEN_W-1:0] gen_counter;
  logic             cell_r;
  logic [31:0]      live_ext;
  logic             cur_bit;
  logic             out_free;

  assign row_ext = 32'(lat_row);
  assign col_ext = 32'(lat_col);
  assign row_a   = row_ext[RW-1:0];
  assign col_a   = col_ext[RW-1:0];
  assign cur_bit = rd_data[col_a];
  assign out_free = !res_valid || res_ready;

  // Status to the controller.
  assign st.mode     = lat_mode;
  assign st.in_grid  = in_grid;
  assign st.row_last = (rr == RW'(GRID_DIM - 1));
  assign st.gen_last = (rr == RW'(GRID_DIM - 2));
  assign st.col_last = (cc == RW'(GRID_DIM - 3));
  assign st.out_free = out_free;

  // Birth and survival rule on the 3x3 window at the low end of the shifters.
  assign nsum = 4'(sa[0]) + 4'(sa[1]) + 4'(sa[2]) + 4'(sh[0]) + 4'(sh[2])
              + 4'(sb[0]) + 4'(sb[1]) + 4'(sb[2]);
  assign nxt  = (nsum == 4'd3) || (nsum == 4'd2 && sh[1]);

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rr;
    wr_en   = 1'b0;
    wr_addr = rr;
    wr_data = '0;
    unique case (cmd.op)
      OP_ZERO_ROW: wr_en = 1'b1;
      OP_G0: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      OP_G1: begin
        rd_en   = 1'b1;
        rd_addr = RW'(1);
      end
      OP_G2: begin
        rd_en   = 1'b1;
        rd_addr = RW'(2);
      end
      OP_GWR: begin
        wr_en   = 1'b1;
        wr_data = {here[GRID_DIM-1], comp, here[0]};
        rd_en   = !st.gen_last;
        rd_addr = rr + RW'(2);
      end
      OP_RD: begin
        rd_en   = 1'b1;
        rd_addr = row_a;
      end
      OP_MOD: begin
        wr_en   = (lat_mode == MODE_TOGGLE);
        wr_addr = row_a;
        wr_data = rd_data ^ ({{(GRID_DIM-1){1'b0}}, 1'b1} << col_a);
      end
      OP_NONE, OP_GLD, OP_GCOL, OP_DONE: ;
      default: ;
    endcase
  end

  // Row memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= grid_mem[rd_addr];
    end
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lat_mode <= mode_t'(item_mode);
      lat_row  <= item_row;
      lat_col  <= item_col;
      in_grid  <= (32'(item_row) < 32'(GRID_DIM)) && (32'(item_col) < 32'(GRID_DIM));
    end
  end

  // Row and column counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      rr <= '0;
      cc <= '0;
    end else begin
      priority if (cmd.take) begin
        rr <= '0;
      end else if (cmd.op == OP_ZERO_ROW) begin
        rr <= st.row_last ? '0 : rr + RW'(1);
      end else if (cmd.op == OP_G2) begin
        rr <= RW'(1);
      end else if (cmd.op == OP_GWR) begin
        rr <= rr + RW'(1);
      end
      if (cmd.op == OP_GLD) begin
        cc <= '0;
      end else if (cmd.op == OP_GCOL) begin
        cc <= cc + RW'(1);
      end
    end
  end

  // Line buffers and column shifters.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_G1: above <= rd_data;
      OP_G2: here  <= rd_data;
      OP_GLD: begin
        sa    <= above;
        sh    <= here;
        sb    <= rd_data;
        below <= rd_data;
      end
      OP_GCOL: begin
        sa   <= sa >> 1;
        sh   <= sh >> 1;
        sb   <= sb >> 1;
        comp <= {nxt, comp[GRID_DIM-3:1]};
      end
      OP_GWR: begin
        above <= here;
        here  <= below;
      end
      default: ;
    endcase
  end

  // Live and generation counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      live_total  <= '0;
      gen_counter <= '0;
    end else begin
      priority case (cmd.op)
        OP_ZERO_ROW: begin
          if (rr == '0) begin
            live_total  <= '0;
            gen_counter <= '0;
          end
        end
        OP_GCOL: begin
          if (nxt != sh[1]) begin
            live_total <= nxt ? live_total + LW'(1) : live_total - LW'(1);
          end
        end
        OP_GWR: begin
          if (st.gen_last) begin
            gen_counter <= gen_counter + GEN_W'(1);
          end
        end
        OP_MOD: begin
          if (lat_mode == MODE_TOGGLE) begin
            live_total <= cur_bit ? live_total - LW'(1) : live_total + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Addressed cell after the operation.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cell_r <= 1'b0;
    end else if (cmd.op == OP_MOD) begin
      cell_r <= (lat_mode == MODE_TOGGLE) ? !cur_bit : cur_bit;
    end
  end

  // Result register.
  assign live_ext = 32'(live_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.op == OP_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DONE && out_free) begin
      res_cell  <= cell_r;
      res_alive <= (live_ext > 32'(ALIVE_MAX)) ? ALIVE_MAX : live_ext[ALIVE_W-1:0];
      res_gen   <= gen_counter;
    end
  end

`ifndef SYNTHESIS
  // The live count never exceeds the number of cells.
  a_live_range: assert property (@(posedge clk) disable iff (rst)
    live_total <= LW'(GRID_DIM * GRID_DIM))
    else $error("live count out of range");

  // The generation counter moves only at the end of a sweep or on a clear.
  a_gen_move: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && gen_counter != $past(gen_counter)
      |-> $past(cmd.op == OP_GWR) || $past(cmd.op == OP_ZERO_ROW))
    else $error("generation counter changed unexpectedly");

  // A toggle always changes the live count.
  a_toggle_live: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_MOD && lat_mode == MODE_TOGGLE |=> live_total != $past(live_total))
    else $error("toggle did not change the live count");
`endif

endmodule

`default_nettype wire

/* sv/life_grid_engine.sv */
// Top level of the life grid engine: B3/S23 cellular automaton on a square grid.
// Depends on lge_pkg, lge_in_if, lge_out_if, lge_ctrl and lge_datapath.
//
//   channel  | dir | fields
//   ---------+-----+--------------------------------------
//   item     | in  | mode[1:0], row[5:0], col[5:0]
//   result   | out | cell_value, alive_count[12:0], generation[31:0]
//
// Toggle and read: dispatch, row read, modify, then result (outside the grid: dispatch, then result);
// clear zeroes every row. A generation loads the first rows into the line buffers, then sweeps
// the columns of each interior row and writes that row back.
// After reset a clearing pass zeroes the grid; item.ready is low.
// A result held by a stalled sink does not stop the next beat from being accepted;
// the block then waits only at the end of that next operation.
`default_nettype none

module life_grid_engine #(
  parameter int GRID_DIM = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  lge_in_if.sink    item,
  lge_out_if.source result
);
  import lge_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Sequencer.
  lge_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .st         (st),
    .cmd        (cmd)
  );

  // Grid storage and update logic.
  lge_datapath #(
    .GRID_DIM (GRID_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .item_mode (item.mode),
    .item_row  (item.row),
    .item_col  (item.col),
    .res_ready (result.ready),
    .res_valid (result.valid),
    .res_cell  (result.cell_value),
    .res_alive (result.alive_count),
    .res_gen   (result.generation)
  );

endmodule

`default_nettype wire
